// File: src/trc_pkg.sv
// trc_pkg: shared types, codes and the microcode ROM of the three-rotor reflecting cipher.
// No dependencies; used by trc_seq, trc_datapath and the top level.
package trc_pkg;

  localparam int LW         = 5;   // letter field width
  localparam int NUM_ROTORS = 3;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int STEP_W     = 4;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_OFFSET   = 2'd1,
    OP_CIPHER   = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  // Table selects
  localparam logic [2:0] TBL_PLUG   = 3'd0;
  localparam logic [2:0] TBL_ROT0   = 3'd1;
  localparam logic [2:0] TBL_ROT1   = 3'd2;
  localparam logic [2:0] TBL_ROT2   = 3'd3;
  localparam logic [2:0] TBL_REFL   = 3'd4;

  // Rotor selects
  localparam logic [1:0] ROT_ENTRY  = 2'd0;
  localparam logic [1:0] ROT_MIDDLE = 2'd1;
  localparam logic [1:0] ROT_LAST   = 2'd2;

  typedef struct packed {
    op_e             op;
    logic [2:0]      tsel;
    logic [LW-1:0]   eidx;
    logic [LW-1:0]   eval;
    logic [1:0]      rsel;
    logic [LW-1:0]   pos;
    logic [LW-1:0]   letter;
    logic [2:0]      mask;
  } in_item_t;

  // Datapath micro-operations
  typedef enum logic [2:0] {
    UOP_NOP   = 3'd0,
    UOP_ADMIN = 3'd1,  // table load / offset set / rotor advance
    UOP_PLUG  = 3'd2,
    UOP_FWD   = 3'd3,
    UOP_REFL  = 3'd4,
    UOP_BCMP  = 3'd5,  // backward step, compare all entries
    UOP_BRES  = 3'd6,  // backward step, pick highest match
    UOP_EMIT  = 3'd7
  } uop_e;

  typedef enum logic [1:0] {
    JMP_NEXT       = 2'd0,
    JMP_EXIT_NOCPH = 2'd1,  // leave the program unless the item enciphers
    JMP_EXIT       = 2'd2
  } jmp_e;

  typedef struct packed {
    uop_e       uop;
    logic [1:0] rotor;
    jmp_e       jmp;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{uop: UOP_NOP, rotor: ROT_ENTRY, jmp: JMP_EXIT};
    unique case (step)
      4'd0:    w = '{uop: UOP_ADMIN, rotor: ROT_ENTRY,  jmp: JMP_EXIT_NOCPH};
      4'd1:    w = '{uop: UOP_PLUG,  rotor: ROT_ENTRY,  jmp: JMP_NEXT};
      4'd2:    w = '{uop: UOP_FWD,   rotor: ROT_ENTRY,  jmp: JMP_NEXT};
      4'd3:    w = '{uop: UOP_FWD,   rotor: ROT_MIDDLE, jmp: JMP_NEXT};
      4'd4:    w = '{uop: UOP_FWD,   rotor: ROT_LAST,   jmp: JMP_NEXT};
      4'd5:    w = '{uop: UOP_REFL,  rotor: ROT_ENTRY,  jmp: JMP_NEXT};
      4'd6:    w = '{uop: UOP_BCMP,  rotor: ROT_LAST,   jmp: JMP_NEXT};
      4'd7:    w = '{uop: UOP_BRES,  rotor: ROT_LAST,   jmp: JMP_NEXT};
      4'd8:    w = '{uop: UOP_BCMP,  rotor: ROT_MIDDLE, jmp: JMP_NEXT};
      4'd9:    w = '{uop: UOP_BRES,  rotor: ROT_MIDDLE, jmp: JMP_NEXT};
      4'd10:   w = '{uop: UOP_BCMP,  rotor: ROT_ENTRY,  jmp: JMP_NEXT};
      4'd11:   w = '{uop: UOP_BRES,  rotor: ROT_ENTRY,  jmp: JMP_NEXT};
      4'd12:   w = '{uop: UOP_PLUG,  rotor: ROT_ENTRY,  jmp: JMP_NEXT};
      4'd13:   w = '{uop: UOP_EMIT,  rotor: ROT_ENTRY,  jmp: JMP_EXIT};
      default: w = '{uop: UOP_NOP,   rotor: ROT_ENTRY,  jmp: JMP_EXIT};
    endcase
    return w;
  endfunction

endpackage

// File: src/trc_seq.sv
// trc_seq: step counter and microcode fetch for the cipher core.
// Depends on trc_pkg (control word type and ROM).
module trc_seq
  import trc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,     // item transfer into the core
  input  logic  cipher_i,    // captured item enciphers
  input  logic  stall_i,     // hold the current step
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  ctrl_t             word;
  logic              leave;

  assign word = ucode_rom(step_q);

  always_comb begin
    ctrl_o = busy_q ? word : '{uop: UOP_NOP, rotor: ROT_ENTRY, jmp: JMP_EXIT};
  end

  always_comb begin
    leave = 1'b0;
    unique case (word.jmp)
      JMP_EXIT:       leave = 1'b1;
      JMP_EXIT_NOCPH: leave = !cipher_i;
      default:        leave = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q && !stall_i) begin
      if (leave) begin
        step_d = '0;
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// File: src/trc_datapath.sv
// trc_datapath: substitution tables, rotor offsets and the letter register.
// Depends on trc_pkg; driven by the control word from trc_seq.
module trc_datapath
  import trc_pkg::*;
#(
  parameter int LETTERS = 26
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ctrl_t                            ctrl_i,
  input  in_item_t                         item_i,
  output logic [LW-1:0]                    letter_o,
  output logic [NUM_ROTORS-1:0][LW-1:0]    offsets_o
);

  localparam int         IW       = $clog2(LETTERS);
  localparam int         MOD_N    = 64;
  localparam logic [5:0] LETTERS_W = 6'(LETTERS);

  function automatic logic [MOD_N*IW-1:0] build_mod_tbl();
    logic [MOD_N*IW-1:0] t;
    int                  r;
    t = '0;
    r = 0;
    for (int i = 0; i < MOD_N; i++) begin
      t[i*IW +: IW] = IW'(r);
      r = (r == LETTERS - 1) ? 0 : r + 1;
    end
    return t;
  endfunction

  localparam logic [MOD_N*IW-1:0] MOD_TBL = build_mod_tbl();

  function automatic logic [IW-1:0] mod_l(input logic [5:0] v);
    return MOD_TBL[int'(v)*IW +: IW];
  endfunction

  logic [LW-1:0] plug_q [LETTERS];
  logic [LW-1:0] rot0_q [LETTERS];
  logic [LW-1:0] rot1_q [LETTERS];
  logic [LW-1:0] rot2_q [LETTERS];
  logic [LW-1:0] refl_q [LETTERS];

  logic [IW-1:0]      off_q [NUM_ROTORS];
  logic [IW-1:0]      off_d [NUM_ROTORS];
  logic [LW-1:0]      x_q, x_d;
  logic [LETTERS-1:0] match_q, match_d;

  logic [IW-1:0] off_sel;
  logic [IW-1:0] fwd_idx;
  logic [LW-1:0] fwd_val;
  logic [IW-1:0] hit;
  logic [IW:0]   back_val;
  logic          load_ok;
  logic [IW-1:0] widx;

  assign off_sel = off_q[ctrl_i.rotor];
  assign fwd_idx = mod_l(6'(x_q) + 6'(off_sel));
  assign widx    = item_i.eidx[IW-1:0];
  assign load_ok = (ctrl_i.uop == UOP_ADMIN) && (item_i.op == OP_LOAD)
                   && (6'(item_i.eidx) < LETTERS_W);

  always_comb begin
    unique case (ctrl_i.rotor)
      ROT_MIDDLE: fwd_val = rot1_q[fwd_idx];
      ROT_LAST:   fwd_val = rot2_q[fwd_idx];
      default:    fwd_val = rot0_q[fwd_idx];
    endcase
  end

  // Compare every entry of the selected rotor against the letter
  always_comb begin
    for (int i = 0; i < LETTERS; i++) begin
      unique case (ctrl_i.rotor)
        ROT_MIDDLE: match_d[i] = (rot1_q[i] == x_q);
        ROT_LAST:   match_d[i] = (rot2_q[i] == x_q);
        default:    match_d[i] = (rot0_q[i] == x_q);
      endcase
    end
  end

  // Highest matching index wins
  always_comb begin
    hit = '0;
    for (int i = 0; i < LETTERS; i++) begin
      if (match_q[i]) hit = IW'(i);
    end
    if (hit >= off_sel) back_val = (IW+1)'(hit) - (IW+1)'(off_sel);
    else                back_val = (IW+1)'(hit) + (IW+1)'(LETTERS) - (IW+1)'(off_sel);
  end

  always_comb begin
    x_d = x_q;
    for (int r = 0; r < NUM_ROTORS; r++) off_d[r] = off_q[r];
    case (ctrl_i.uop)
      UOP_ADMIN: begin
        if (item_i.op == OP_OFFSET) begin
          if (item_i.rsel < 2'(NUM_ROTORS)) off_d[item_i.rsel] = mod_l(6'(item_i.pos));
        end else if (item_i.op == OP_CIPHER) begin
          for (int r = 0; r < NUM_ROTORS; r++) begin
            if (item_i.mask[r]) begin
              off_d[r] = (off_q[r] == IW'(LETTERS - 1)) ? '0 : off_q[r] + 1'b1;
            end
          end
          x_d = item_i.letter;
        end
      end
      UOP_PLUG: begin
        if (6'(x_q) < LETTERS_W) x_d = plug_q[x_q[IW-1:0]];
      end
      UOP_FWD:  x_d = fwd_val;
      UOP_REFL: x_d = refl_q[mod_l(6'(x_q))];
      UOP_BRES: begin
        if (match_q == '0) x_d = LW'(LETTERS - 1);
        else               x_d = LW'(back_val[IW-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROTORS; r++) off_q[r] <= '0;
    end else begin
      for (int r = 0; r < NUM_ROTORS; r++) off_q[r] <= off_d[r];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (ctrl_i.uop == UOP_BCMP) match_q <= match_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      unique case (item_i.tsel)
        TBL_PLUG: plug_q[widx] <= item_i.eval;
        TBL_ROT0: rot0_q[widx] <= item_i.eval;
        TBL_ROT1: rot1_q[widx] <= item_i.eval;
        TBL_ROT2: rot2_q[widx] <= item_i.eval;
        TBL_REFL: refl_q[widx] <= item_i.eval;
        default: ;
      endcase
    end
  end

  assign letter_o = x_q;
  always_comb begin
    for (int r = 0; r < NUM_ROTORS; r++) offsets_o[r] = LW'(off_q[r]);
  end

endmodule

// File: src/three_rotor_reflecting_cipher_core.sv
// three_rotor_reflecting_cipher_core: top level of the reflecting rotor cipher.
// Depends on trc_pkg, trc_seq and trc_datapath.
//
//  channel  | dir | tdata fields (low bit up)                                | tuser
//  s_axis   | in  | table_select, entry_index, entry_value, rotor_select,     | op
//           |     | position_value, plain_letter, advance_mask, pad to 32     |
//  m_axis   | out | cipher_letter, offset_entry, offset_middle, offset_last, | -
//           |     | pad to 24                                                 |
//
// An encipher transfer runs a 14-step microprogram, set by the sequencer, which
// takes one step per cycle unless the emit step stalls, and by the backward
// search (compare step, then pick step) of each rotor. Table loads, offset sets
// and reserved items run only the admin step and give no result.
// Reset clears the sequencer, the rotor offsets and the result flag; the
// tables hold nothing defined until loaded.
// A result waits in the output register while the next item is taken; the
// program holds on its emit step only if that register is still full.
module three_rotor_reflecting_cipher_core
  import trc_pkg::*;
#(
  parameter int LETTERS = 26
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // table_select[2:0], entry_index[7:3], entry_value[12:8], rotor_select[14:13],
  // position_value[19:15], plain_letter[24:20], advance_mask[27:25], zero[31:28]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // cipher_letter[4:0], offset_entry[9:5], offset_middle[14:10],
  // offset_last[19:15], zero[23:20]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  in_item_t                      item_q;
  ctrl_t                         ctrl;
  logic                          busy;
  logic                          in_xfer;
  logic                          stall;
  logic                          emit;
  logic [LW-1:0]                 letter;
  logic [NUM_ROTORS-1:0][LW-1:0] offsets;
  logic                          out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]         out_data_q;

  // Accept a new item whenever no program runs
  assign s_axis_tready_o = !busy;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Capture the item; it stays put for the whole program
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.op     <= op_e'(s_axis_tuser_i[1:0]);
      item_q.tsel   <= s_axis_tdata_i[2:0];
      item_q.eidx   <= s_axis_tdata_i[7:3];
      item_q.eval   <= s_axis_tdata_i[12:8];
      item_q.rsel   <= s_axis_tdata_i[14:13];
      item_q.pos    <= s_axis_tdata_i[19:15];
      item_q.letter <= s_axis_tdata_i[24:20];
      item_q.mask   <= s_axis_tdata_i[27:25];
    end
  end

  // Hold on the emit step while the previous result is still unclaimed
  assign stall = (ctrl.uop == UOP_EMIT) && out_valid_q && !m_axis_tready_i;
  assign emit  = (ctrl.uop == UOP_EMIT) && !stall;

  trc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xfer),
    .cipher_i (item_q.op == OP_CIPHER),
    .stall_i  (stall),
    .busy_o   (busy),
    .ctrl_o   (ctrl)
  );

  trc_datapath #(
    .LETTERS (LETTERS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .item_i    (item_q),
    .letter_o  (letter),
    .offsets_o (offsets)
  );

  // Output register: load on emit, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit)                                out_valid_d = 1'b1;
    else if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {4'b0000, offsets[ROT_LAST], offsets[ROT_MIDDLE],
                     offsets[ROT_ENTRY], letter};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
